// ----- rtl/core/pgw_pkg.sv -----
// Shared types, codes and helpers for the two-level page walk MMU.
`timescale 1ns / 1ps
`default_nettype none

package pgw_pkg;

	// Input word functions.
	localparam logic [1:0] FUNC_TRANSLATE = 2'd0;
	localparam logic [1:0] FUNC_READ_DATA = 2'd1;
	localparam logic [1:0] FUNC_CLEAR     = 2'd2;

	// Validate modes.
	localparam logic [1:0] VM_READ  = 2'd1;
	localparam logic [1:0] VM_WRITE = 2'd2;

	// Bus status code of a read-modify-write cycle.
	localparam logic [3:0] CS_RMW = 4'd11;

	// Result kinds.
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Result outcomes.
	localparam logic [1:0] OUT_COMPLETE = 2'd0;
	localparam logic [1:0] OUT_ABORT    = 2'd1;
	localparam logic [1:0] OUT_CANCEL   = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_BASE_USER  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_BASE_DUAL  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_XLATE_USER = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_XLATE_SUP  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DUAL_SPACE = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_LEVEL_OVR  = 3'd5;

	// Result queue geometry.
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_L1,
		PH_L2
	} phase_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] vaddr;
		logic        user_mode;
		logic        is_write;
		logic [3:0]  cycle_status;
		logic        probe;
		logic [1:0]  validate_mode;
		logic [31:0] read_data;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [15:0] write_data;
		logic [1:0]  outcome;
		logic        fault_flag;
		logic        error_seen;
		logic [2:0]  error_type;
		logic        error_on_read;
		logic [2:0]  error_cycle;
		logic [23:0] error_vaddr;
		logic        error_space;
	} out_word_t;

	typedef struct packed {
		logic [31:0] base_user;
		logic [31:0] base_dual;
		logic        xlate_user;
		logic        xlate_sup;
		logic        dual_space;
		logic        level_ovr;
	} cfg_t;

	// Words handed from the front end to the result queue in one cycle.
	typedef struct packed {
		logic [1:0] n;
		out_word_t  w0;
		out_word_t  w1;
	} push_t;

endpackage

`default_nettype wire

// ----- rtl/core/two_level_page_walk_mmu_top.sv -----
// Top level of the two-level page walk MMU: configuration registers and the two halves.
//
// Usage: input words (func, vaddr, access attributes, returned entry data) arrive on
// in_valid/in_ready; result words (entry read requests, entry write-backs, translation
// done with outcome and the error status) leave on out_valid/out_ready. One input word
// is accepted per cycle while the result queue has two free slots. An input word
// causes zero, one or two result words; they are written into the queue when the word
// is accepted and leave it in order, one word per cycle while the receiver is ready,
// so two results of one word leave one after the other. The four-entry result queue
// decouples the sides: when the receiver stalls, accepted words keep their results in
// the queue and in_ready falls once fewer than two slots remain. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at the next edge and are meant for idle
// periods. Reset clears the configuration, the walk state and the error status and
// empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_walk_mmu_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire pgw_pkg::in_word_t            in_word,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output pgw_pkg::out_word_t                out_word,
	input  wire logic                         cfg_we,
	input  wire logic [pgw_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [31:0]                  cfg_data
);
	import pgw_pkg::*;

	cfg_t  cfg_q;
	push_t push;
	logic  accept;
	logic  room;

	assign in_ready = room;
	assign accept   = in_valid & room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_USER:  cfg_q.base_user  <= cfg_data;
				CFG_BASE_DUAL:  cfg_q.base_dual  <= cfg_data;
				CFG_XLATE_USER: cfg_q.xlate_user <= cfg_data[0];
				CFG_XLATE_SUP:  cfg_q.xlate_sup  <= cfg_data[0];
				CFG_DUAL_SPACE: cfg_q.dual_space <= cfg_data[0];
				CFG_LEVEL_OVR:  cfg_q.level_ovr  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pgw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_word (in_word),
		.cfg     (cfg_q),
		.push    (push)
	);

	pgw_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

// ----- rtl/core/pgw_front.sv -----
// Front end: decodes input words, runs the walk state and error status, forms result words.
`timescale 1ns / 1ps
`default_nettype none

module pgw_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire pgw_pkg::in_word_t in_word,
	input  wire pgw_pkg::cfg_t  cfg,
	output pgw_pkg::push_t      push
);
	import pgw_pkg::*;

	phase_t      phase_q, phase_d;
	logic [23:0] held_vaddr_q, held_vaddr_d;
	logic [6:0]  held_flags_q, held_flags_d;
	logic [2:0]  held_level_q, held_level_d;
	logic [31:0] first_entry_q, first_entry_d;
	logic [24:0] entry_addr_q, entry_addr_d;
	logic [7:0]  st_err_q, st_err_d;
	logic [24:0] st_addr_q, st_addr_d;

	logic [31:0] pte;
	logic        prot, inval, normal, fail;
	logic        h_write, h_probe, h_space;
	logic [2:0]  h_st;
	logic [7:0]  fail_err;
	logic        fail_abort;

	logic        t_xlate, t_write, t_valid, t_space, t_wlevel;
	logic [2:0]  t_level;
	logic [31:0] t_base;

	out_word_t   r0, r1;
	logic [1:0]  n;

	assign pte     = in_word.read_data;
	assign h_write = held_flags_q[0];
	assign h_probe = held_flags_q[1];
	assign h_space = held_flags_q[3];
	assign h_st    = held_flags_q[6:4];
	assign prot    = held_level_q > {pte[2:1], 1'b0};
	assign inval   = ~pte[0];
	assign normal  = ~held_flags_q[2];
	assign fail    = prot | inval;
	assign fail_err = {h_st, ~h_write, inval & (phase_q == PH_L2),
		inval & (phase_q == PH_L1), prot, 1'b1};
	// A missing level-1 entry aborts even in validate mode.
	assign fail_abort = normal | (inval & (phase_q == PH_L1));

	assign t_xlate  = in_word.user_mode ? cfg.xlate_user : cfg.xlate_sup;
	assign t_write  = in_word.is_write | (in_word.validate_mode == VM_WRITE);
	assign t_valid  = (in_word.validate_mode == VM_READ) ||
		(in_word.validate_mode == VM_WRITE);
	assign t_space  = cfg.dual_space & in_word.user_mode;
	assign t_wlevel = t_write | (in_word.cycle_status == CS_RMW);
	assign t_level  = (in_word.user_mode && !cfg.level_ovr) ?
		(t_wlevel ? 3'd6 : 3'd4) : (t_wlevel ? 3'd2 : 3'd0);
	assign t_base   = t_space ? cfg.base_dual : cfg.base_user;

	always_comb begin
		phase_d       = phase_q;
		held_vaddr_d  = held_vaddr_q;
		held_flags_d  = held_flags_q;
		held_level_d  = held_level_q;
		first_entry_d = first_entry_q;
		entry_addr_d  = entry_addr_q;
		st_err_d      = st_err_q;
		st_addr_d     = st_addr_q;
		n             = 2'd0;
		r0            = '0;
		r1            = '0;
		if (accept) begin
			case (in_word.func)
				FUNC_CLEAR: begin
					st_err_d = '0;
				end
				FUNC_TRANSLATE: begin
					if (phase_q == PH_IDLE) begin
						if (!t_xlate) begin
							n          = 2'd1;
							r0.kind    = KIND_DONE;
							r0.address = in_word.vaddr;
						end else begin
							held_level_d = t_level;
							if (!t_valid && !in_word.probe) begin
								st_err_d = '0;
							end
							held_vaddr_d = in_word.vaddr[23:0];
							held_flags_d = {in_word.cycle_status[2:0], t_space, t_valid,
								in_word.probe, t_write};
							entry_addr_d = {t_base[31], t_base[23:10],
								in_word.vaddr[23:16], 2'b00};
							phase_d      = PH_L1;
							n            = 2'd1;
							r0.kind      = KIND_READ;
							r0.address   = {7'd0, entry_addr_d};
						end
					end
				end
				FUNC_READ_DATA: begin
					if (phase_q != PH_IDLE) begin
						if (fail) begin
							if (normal && !h_probe) begin
								st_err_d  = st_err_q | fail_err;
								st_addr_d = {h_space, held_vaddr_q};
							end
							phase_d       = PH_IDLE;
							n             = 2'd1;
							r0.kind       = KIND_DONE;
							r0.address    = {8'd0, held_vaddr_q};
							r0.outcome    = fail_abort ? OUT_ABORT : OUT_CANCEL;
							r0.fault_flag = ~fail_abort;
						end else if (phase_q == PH_L1) begin
							first_entry_d = pte;
							entry_addr_d  = {pte[31], pte[23:9], held_vaddr_q[15:9], 2'b00};
							phase_d       = PH_L2;
							if (!pte[3] && !h_probe) begin
								n             = 2'd2;
								r0.kind       = KIND_WRITE;
								r0.address    = {7'd0, entry_addr_q};
								r0.write_data = pte[15:0] | 16'h0008;
								r1.kind       = KIND_READ;
								r1.address    = {7'd0, entry_addr_d};
							end else begin
								n          = 2'd1;
								r0.kind    = KIND_READ;
								r0.address = {7'd0, entry_addr_d};
							end
						end else begin
							phase_d = PH_IDLE;
							if ((!pte[3] || (h_write && !pte[4])) && !h_probe) begin
								n             = 2'd2;
								r0.kind       = KIND_WRITE;
								r0.address    = {7'd0, entry_addr_q};
								r0.write_data = pte[15:0] | {11'd0, h_write, 4'h8};
								r1.kind       = KIND_DONE;
								r1.address    = {7'd0, first_entry_q[31], pte[23:9],
									held_vaddr_q[8:0]};
							end else begin
								n          = 2'd1;
								r0.kind    = KIND_DONE;
								r0.address = {7'd0, first_entry_q[31], pte[23:9],
									held_vaddr_q[8:0]};
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		// Every result reports the error status as it stands after this word.
		r0.error_seen    = st_err_d[0];
		r0.error_type    = st_err_d[3:1];
		r0.error_on_read = st_err_d[4];
		r0.error_cycle   = st_err_d[7:5];
		r0.error_vaddr   = st_addr_d[23:0];
		r0.error_space   = st_addr_d[24];
		r1.error_seen    = st_err_d[0];
		r1.error_type    = st_err_d[3:1];
		r1.error_on_read = st_err_d[4];
		r1.error_cycle   = st_err_d[7:5];
		r1.error_vaddr   = st_addr_d[23:0];
		r1.error_space   = st_addr_d[24];
	end

	assign push.n  = n;
	assign push.w0 = r0;
	assign push.w1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			held_vaddr_q <= '0;
			held_flags_q <= '0;
			held_level_q <= '0;
			st_err_q     <= '0;
			st_addr_q    <= '0;
		end else begin
			phase_q      <= phase_d;
			held_vaddr_q <= held_vaddr_d;
			held_flags_q <= held_flags_d;
			held_level_q <= held_level_d;
			st_err_q     <= st_err_d;
			st_addr_q    <= st_addr_d;
		end
	end

	always_ff @(posedge clk) begin
		first_entry_q <= first_entry_d;
		entry_addr_q  <= entry_addr_d;
	end

	a_l2_ends: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_word.func == FUNC_READ_DATA && phase_q == PH_L2 |=> phase_q == PH_IDLE)
		else $error("walk did not end after level-2 entry");

	a_walk_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_word.func == FUNC_TRANSLATE && phase_q == PH_IDLE && t_xlate
		|=> phase_q == PH_L1)
		else $error("translate request did not start a walk");

	a_entry_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_word.func == FUNC_READ_DATA && phase_q != PH_IDLE |-> push.n != 2'd0)
		else $error("entry word produced no result");

endmodule

`default_nettype wire

// ----- rtl/core/pgw_rq.sv -----
// Back end: result queue that takes up to two words a cycle and delivers one while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module pgw_rq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pgw_pkg::push_t  push,
	output logic                 room,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output pgw_pkg::out_word_t   out_word
);
	import pgw_pkg::*;

	out_word_t          mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [RQ_CW-1:0]   count_q;
	logic               pop;
	logic [RQ_AW-1:0]   wr_ptr1;

	assign pop       = out_valid & out_ready;
	assign out_valid = count_q != '0;
	assign out_word  = mem_q[rd_ptr_q];
	// Room for the largest burst one input word can cause.
	assign room      = count_q <= RQ_CW'(RQ_DEPTH - 2);
	assign wr_ptr1   = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr1] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + RQ_CW'(push.n) - RQ_CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RQ_CW'(RQ_DEPTH))
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> count_q <= RQ_CW'(RQ_DEPTH - 2))
		else $error("push without room");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("more than two words pushed");

endmodule

`default_nettype wire
